@@ sv/urrs_pkg.sv @@
// shared types and constants of the uniform range rejection sampler
`default_nettype none

package urrs_pkg;

   localparam int VALUE_W = 64;
   localparam int WORD_W  = 32;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_ORDER   = 2'd1,
      STAT_WIDE    = 2'd2,
      STAT_ENTROPY = 2'd3
   } status_type;

   typedef enum logic {
      KIND_RANGE = 1'b0,
      KIND_WORD  = 1'b1
   } req_kind_type;

endpackage

`default_nettype wire

@@ sv/urrs_req_if.sv @@
// request channel: range requests and entropy words
`default_nettype none

interface urrs_req_if import urrs_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic signed [VALUE_W-1:0]  range_low;
   logic signed [VALUE_W-1:0]  range_high;
   logic        [WORD_W-1:0]   entropy_word;
   logic                       entropy_ok;

   modport source (output valid, output req_type, output range_low, output range_high,
                   output entropy_word, output entropy_ok, input ready);
   modport sink (input valid, input req_type, input range_low, input range_high,
                 input entropy_word, input entropy_ok, output ready);
endinterface

`default_nettype wire

@@ sv/urrs_rsp_if.sv @@
// result channel: sample and status
`default_nettype none

interface urrs_rsp_if import urrs_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  sample;
   status_type                 status;

   modport source (output valid, output sample, output status, input ready);
   modport sink (input valid, input sample, input status, output ready);
endinterface

`default_nettype wire

@@ sv/urrs_mod_unit.sv @@
// bit-serial restoring remainder unit, one dividend bit per cycle
`default_nettype none

module urrs_mod_unit #(
   parameter int W = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      remainder
);

   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]     quo_ff, quo_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;
   logic [W:0]       diff;

   assign trial = {rem_ff, quo_ff[W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[W-2:0], 1'b0};
         rem_in = diff[W] ? trial[W-1:0] : diff[W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTHESIS
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("start while busy");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("busy with empty count");
`endif

endmodule

`default_nettype wire

@@ sv/uniform_range_rejection_sampler_unit.sv @@
// top level of the uniform range rejection sampler
// range request: threshold computed in ST_DIV unless full span or in error
// entropy word: a word at or above the threshold goes through ST_DIV, then ST_EMIT
// full span words, failures and range errors: straight to ST_EMIT, back to ST_IDLE
// throughput: bit-serial remainder, one dividend bit per cycle; stalls on rsp ready
// synchronous reset clears the state, the pending request and the result valid flag
`default_nettype none

module uniform_range_rejection_sampler_unit import urrs_pkg::*; #(
   parameter int ENTROPY_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   urrs_req_if.sink  req_if,
   urrs_rsp_if.source rsp_if
);

   localparam int EB = ENTROPY_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic                  pending_ff, pending_in;
   logic                  is_sample_ff, is_sample_in;
   logic [VALUE_W-1:0]    base_ff, base_in;
   logic [EB-1:0]         dist_ff, dist_in;
   logic                  full_ff, full_in;
   logic [EB-1:0]         limit_ff, limit_in;
   logic [EB-1:0]         offset_ff, offset_in;
   logic                  res_ok_ff, res_ok_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_sample_ff, rsp_sample_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  order_bad;
   logic [VALUE_W-1:0]    dist_full;
   logic                  too_wide;
   logic [EB-1:0]         word;
   logic                  mod_start;
   logic [EB-1:0]         mod_dividend;
   logic [EB-1:0]         mod_divisor;
   logic                  mod_done;
   logic [EB-1:0]         mod_rem;

   assign accept    = req_if.valid && req_if.ready;
   assign order_bad = req_if.range_low > req_if.range_high;
   assign dist_full = VALUE_W'(req_if.range_high) - VALUE_W'(req_if.range_low);
   assign too_wide  = |dist_full[VALUE_W-1:EB];
   assign word      = req_if.entropy_word[EB-1:0];

   urrs_mod_unit #(.W(EB)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      state_in      = state_ff;
      pending_in    = pending_ff;
      is_sample_in  = is_sample_ff;
      base_in       = base_ff;
      dist_in       = dist_ff;
      full_in       = full_ff;
      limit_in      = limit_ff;
      offset_in     = offset_ff;
      res_ok_in     = res_ok_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_status_in = rsp_status_ff;
      mod_start     = 1'b0;
      mod_dividend  = word;
      mod_divisor   = dist_ff + EB'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.req_type == KIND_RANGE) begin
                  pending_in = 1'b0;
                  if (order_bad) begin
                     res_ok_in     = 1'b0;
                     res_status_in = STAT_ORDER;
                     state_in      = ST_EMIT;
                  end else if (too_wide) begin
                     res_ok_in     = 1'b0;
                     res_status_in = STAT_WIDE;
                     state_in      = ST_EMIT;
                  end else begin
                     base_in = VALUE_W'(req_if.range_low);
                     dist_in = dist_full[EB-1:0];
                     full_in = &dist_full[EB-1:0];
                     if (&dist_full[EB-1:0]) begin
                        limit_in   = '0;
                        pending_in = 1'b1;
                     end else begin
                        mod_start    = 1'b1;
                        mod_dividend = ~dist_full[EB-1:0];
                        mod_divisor  = dist_full[EB-1:0] + EB'(1);
                        is_sample_in = 1'b0;
                        state_in     = ST_DIV;
                     end
                  end
               end else if (pending_ff) begin
                  if (!req_if.entropy_ok) begin
                     pending_in    = 1'b0;
                     res_ok_in     = 1'b0;
                     res_status_in = STAT_ENTROPY;
                     state_in      = ST_EMIT;
                  end else if (full_ff) begin
                     pending_in    = 1'b0;
                     offset_in     = word;
                     res_ok_in     = 1'b1;
                     res_status_in = STAT_OK;
                     state_in      = ST_EMIT;
                  end else if (word >= limit_ff) begin
                     mod_start    = 1'b1;
                     is_sample_in = 1'b1;
                     state_in     = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               if (is_sample_ff) begin
                  pending_in    = 1'b0;
                  offset_in     = mod_rem;
                  res_ok_in     = 1'b1;
                  res_status_in = STAT_OK;
                  state_in      = ST_EMIT;
               end else begin
                  limit_in   = mod_rem;
                  pending_in = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = res_ok_ff ? base_ff + VALUE_W'(offset_ff) : '0;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      is_sample_ff  <= is_sample_in;
      base_ff       <= base_in;
      dist_ff       <= dist_in;
      full_ff       <= full_in;
      limit_ff      <= limit_in;
      offset_ff     <= offset_in;
      res_ok_ff     <= res_ok_in;
      res_status_ff <= res_status_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.sample = rsp_sample_ff;
   assign rsp_if.status = rsp_status_ff;

`ifndef SYNTHESIS
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == ST_DIV))
      else $error("remainder done outside division");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STAT_OK)) |-> (rsp_sample_ff == '0))
      else $error("error result with nonzero sample");
   a_pending_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (pending_ff == is_sample_ff))
      else $error("pending flag does not match division kind");
`endif

endmodule

`default_nettype wire
